@@ hdl/assert_macros.svh @@
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property, sampled on the rising clock edge, off in reset.
`define WES_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define WES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `WES_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

@@ hdl/wes_pkg.sv @@
package wes_pkg;

  // Default grid limits (inner cells)
  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;

  // Q15 limits
  localparam int Q15_MAX  = 32767;
  localparam int Q15_MIN  = -32768;
  localparam int Q15_FRAC = 15;

  // Register reset values
  localparam logic signed [15:0] RST_COURANT = 16'sd5242;
  localparam logic [3:0]         RST_DAMP    = 4'd6;
  localparam logic [6:0]         RST_WIDTH   = 7'd64;
  localparam logic [6:0]         RST_HEIGHT  = 7'd64;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_RD_CUR = 2'd1,
    FN_RD_PRV = 2'd2,
    FN_STEP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_COURANT = 3'd0,
    REG_DAMP    = 3'd1,
    REG_HALF    = 3'd2,
    REG_CYL     = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_HEIGHT  = 3'd5
  } reg_e;

  typedef struct packed {
    func_e              func;
    logic [5:0]         col;
    logic [5:0]         row;
    logic signed [15:0] cell_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic               in_range;
  } out_t;

  typedef struct packed {
    logic signed [15:0] courant_sq;
    logic [3:0]         damping_shift;
    logic               half_duplex;
    logic               x_cylindrical;
    logic [6:0]         grid_width;
    logic [6:0]         grid_height;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BCOL_RD,
    ST_BCOL_WR,
    ST_BROW_RD,
    ST_BROW_WR,
    ST_CELL_C,
    ST_CELL_E,
    ST_CELL_W,
    ST_CELL_N,
    ST_CELL_S,
    ST_CELL_MUL,
    ST_CELL_F,
    ST_CELL_WR
  } state_e;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_CELL,
    WS_COPY,
    WS_CALC
  } wr_src_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD,
    ACC_MUL,
    ACC_FOLD
  } acc_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_OK,
    EM_CUR,
    EM_PRV
  } emit_e;

  // Controller to datapath command
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    logic    wr_nxt;   // 0: current grid, 1: next (previous) grid
    logic    wr_both;  // clear sweep writes both grids
    wr_src_e wr_src;
    acc_e    acc;
    emit_e   emit;
    logic    emit_ok;
    logic    swap;
  } ctl_t;

endpackage

@@ hdl/wes_dp.sv @@
module wes_dp #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  wes_pkg::cfg_t                                 cfg_i,
  input  wes_pkg::ctl_t                                 ctl_i,
  input  logic [$clog2((MAX_WIDTH+2)*(MAX_HEIGHT+2))-1:0] rd_addr_i,
  input  logic [$clog2((MAX_WIDTH+2)*(MAX_HEIGHT+2))-1:0] wr_addr_i,
  input  logic signed [15:0]                            cell_value_i,
  output logic                                          done_o,
  output wes_pkg::out_t                                 res_o
);
  import wes_pkg::*;

  localparam int unsigned CELLS = (MAX_WIDTH + 2) * (MAX_HEIGHT + 2);
  localparam int unsigned AW    = $clog2(CELLS);

  logic [15:0] mem_a [CELLS];
  logic [15:0] mem_b [CELLS];
  logic signed [15:0] qa_q, qb_q;
  logic active_q;

  logic signed [15:0] cur_rd, prv_rd, wdata, calc_val;
  logic tgt_b, we_a, we_b;

  logic signed [15:0] c_q, p_q;
  logic signed [18:0] acc_q, lap;
  logic signed [34:0] prod_q, prod_sh;
  logic signed [21:0] f_q, bias, quo, damped;

  logic  done_q;
  out_t  res_q;

  assign cur_rd = active_q ? qb_q : qa_q;
  assign prv_rd = active_q ? qa_q : qb_q;

  // Write routing: grid a is current while active_q is low
  assign tgt_b = ctl_i.wr_nxt ^ active_q;
  assign we_a  = ctl_i.wr_en && (ctl_i.wr_both || !tgt_b);
  assign we_b  = ctl_i.wr_en && (ctl_i.wr_both || tgt_b);

  always_comb begin
    unique case (ctl_i.wr_src)
      WS_ZERO: wdata = '0;
      WS_CELL: wdata = cell_value_i;
      WS_COPY: wdata = cur_rd;
      WS_CALC: wdata = calc_val;
      default: wdata = '0;
    endcase
  end

  // Grid memories, registered read
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr_i[AW-1:0]] <= wdata;
    end
    if (ctl_i.rd_en) begin
      qa_q <= mem_a[rd_addr_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wr_addr_i[AW-1:0]] <= wdata;
    end
    if (ctl_i.rd_en) begin
      qb_q <= mem_b[rd_addr_i[AW-1:0]];
    end
  end

  // Laplacian, scaling and update
  assign lap     = acc_q + {{3{cur_rd[15]}}, cur_rd};
  assign prod_sh = prod_q >>> Q15_FRAC;  // floor division by 2^15

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.acc)
      ACC_HOLD: ;
      ACC_INIT: begin
        c_q   <= cur_rd;
        p_q   <= prv_rd;
        acc_q <= -{cur_rd[15], cur_rd, 2'b00};
      end
      ACC_ADD:  acc_q  <= lap;
      ACC_MUL:  prod_q <= 35'(lap) * 35'(cfg_i.courant_sq);
      ACC_FOLD: f_q    <= prod_sh[21:0] - 22'(p_q) + (22'(c_q) <<< 1);
      default: ;
    endcase
  end

  // Damping: f - trunc(f / 2^s), then clamp and optional floor at zero
  always_comb begin
    bias   = f_q[21] ? ((22'sd1 <<< cfg_i.damping_shift) - 22'sd1) : 22'sd0;
    quo    = (f_q + bias) >>> cfg_i.damping_shift;
    damped = f_q - quo;
    priority if (damped > 22'(Q15_MAX)) begin
      calc_val = 16'(Q15_MAX);
    end else if (damped < 22'(Q15_MIN)) begin
      calc_val = 16'(Q15_MIN);
    end else begin
      calc_val = damped[15:0];
    end
    if (cfg_i.half_duplex && calc_val[15]) begin
      calc_val = '0;
    end
  end

  // Grid role and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (ctl_i.swap) begin
        active_q <= ~active_q;
      end
      done_q <= (ctl_i.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.in_range <= ctl_i.emit_ok;
    unique case (ctl_i.emit)
      EM_CUR:  res_q.read_value <= ctl_i.emit_ok ? cur_rd : '0;
      EM_PRV:  res_q.read_value <= ctl_i.emit_ok ? prv_rd : '0;
      default: res_q.read_value <= '0;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hdl/wes_ctrl.sv @@
module wes_ctrl #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  wes_pkg::cfg_t                                   cfg_i,
  input  logic                                            start_i,
  input  wes_pkg::in_t                                    cmd_i,
  output logic                                            busy_o,
  output wes_pkg::ctl_t                                   ctl_o,
  output logic [$clog2((MAX_WIDTH+2)*(MAX_HEIGHT+2))-1:0] rd_addr_o,
  output logic [$clog2((MAX_WIDTH+2)*(MAX_HEIGHT+2))-1:0] wr_addr_o
);
  import wes_pkg::*;

  localparam int unsigned P     = MAX_WIDTH + 2;
  localparam int unsigned CELLS = (MAX_WIDTH + 2) * (MAX_HEIGHT + 2);
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 2);

  state_e state_q, state_d;
  logic [HW-1:0] row_q, row_d;
  logic [WW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d, clr_q, clr_d;
  logic side_q, side_d, ok_q, ok_d, prv_q, prv_d;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic acc_ok;
  logic [AW-1:0] acc_addr, x, hbase, l_src, r_src, r_dst;
  logic last_col, last_row;

  // Effective grid size
  always_comb begin
    if (cfg_i.grid_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_i.grid_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_i.grid_width);
    end
    if (cfg_i.grid_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_i.grid_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_i.grid_height);
    end
  end

  // Addresses
  assign acc_ok   = (32'(cmd_i.col) < 32'(w_eff)) && (32'(cmd_i.row) < 32'(h_eff));
  assign acc_addr = AW'((32'(cmd_i.row) + 1) * P + 32'(cmd_i.col) + 1);
  assign x        = base_q + AW'(col_q);
  assign hbase    = AW'(32'(h_eff) * P);
  assign l_src    = cfg_i.x_cylindrical ? base_q + AW'(w_eff) : base_q + AW'(1);
  assign r_src    = cfg_i.x_cylindrical ? base_q + AW'(1) : base_q + AW'(w_eff);
  assign r_dst    = base_q + AW'(w_eff) + AW'(1);
  assign last_col = (col_q == w_eff);
  assign last_row = (row_q == h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
      col_q   <= '0;
      base_q  <= '0;
      clr_q   <= '0;
      side_q  <= 1'b0;
      ok_q    <= 1'b0;
      prv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
      clr_q   <= clr_d;
      side_q  <= side_d;
      ok_q    <= ok_d;
      prv_q   <= prv_d;
    end
  end

  // Next state and counters
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    base_d  = base_q;
    clr_d   = clr_q;
    side_d  = side_q;
    ok_d    = ok_q;
    prv_d   = prv_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i.func)
            FN_WRITE: ;
            FN_RD_CUR, FN_RD_PRV: begin
              ok_d    = acc_ok;
              prv_d   = (cmd_i.func == FN_RD_PRV);
              state_d = ST_READ;
            end
            FN_STEP: begin
              row_d   = HW'(1);
              base_d  = AW'(P);
              side_d  = 1'b0;
              state_d = ST_BCOL_RD;
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_BCOL_RD: state_d = ST_BCOL_WR;
      ST_BCOL_WR: begin
        side_d = ~side_q;
        if (!side_q) begin
          state_d = ST_BCOL_RD;
        end else if (last_row) begin
          col_d   = '0;
          state_d = ST_BROW_RD;
        end else begin
          row_d   = row_q + HW'(1);
          base_d  = base_q + AW'(P);
          state_d = ST_BCOL_RD;
        end
      end
      ST_BROW_RD: state_d = ST_BROW_WR;
      ST_BROW_WR: begin
        side_d = ~side_q;
        if (!side_q) begin
          state_d = ST_BROW_RD;
        end else if (col_q == w_eff + WW'(1)) begin
          row_d   = HW'(1);
          base_d  = AW'(P);
          col_d   = WW'(1);
          state_d = ST_CELL_C;
        end else begin
          col_d   = col_q + WW'(1);
          state_d = ST_BROW_RD;
        end
      end
      ST_CELL_C:   state_d = ST_CELL_E;
      ST_CELL_E:   state_d = ST_CELL_W;
      ST_CELL_W:   state_d = ST_CELL_N;
      ST_CELL_N:   state_d = ST_CELL_S;
      ST_CELL_S:   state_d = ST_CELL_MUL;
      ST_CELL_MUL: state_d = ST_CELL_F;
      ST_CELL_F:   state_d = ST_CELL_WR;
      ST_CELL_WR: begin
        if (!last_col) begin
          col_d   = col_q + WW'(1);
          state_d = ST_CELL_C;
        end else if (last_row) begin
          state_d = ST_IDLE;
        end else begin
          col_d   = WW'(1);
          row_d   = row_q + HW'(1);
          base_d  = base_q + AW'(P);
          state_d = ST_CELL_C;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl_o     = '0;
    rd_addr_o = '0;
    wr_addr_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_both = 1'b1;
        ctl_o.wr_src  = WS_ZERO;
        wr_addr_o     = clr_q;
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i.func)
            FN_WRITE: begin
              ctl_o.wr_en   = acc_ok;
              ctl_o.wr_src  = WS_CELL;
              ctl_o.emit    = EM_OK;
              ctl_o.emit_ok = acc_ok;
              wr_addr_o     = acc_addr;
            end
            FN_RD_CUR, FN_RD_PRV: begin
              ctl_o.rd_en = acc_ok;
              rd_addr_o   = acc_addr;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ctl_o.emit    = prv_q ? EM_PRV : EM_CUR;
        ctl_o.emit_ok = ok_q;
      end
      ST_BCOL_RD: begin
        ctl_o.rd_en = 1'b1;
        rd_addr_o   = side_q ? r_src : l_src;
      end
      ST_BCOL_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_src = WS_COPY;
        wr_addr_o    = side_q ? r_dst : base_q;
      end
      ST_BROW_RD: begin
        ctl_o.rd_en = 1'b1;
        rd_addr_o   = side_q ? hbase + AW'(col_q) : AW'(P) + AW'(col_q);
      end
      ST_BROW_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_src = WS_COPY;
        wr_addr_o    = side_q ? hbase + AW'(P) + AW'(col_q) : AW'(col_q);
      end
      ST_CELL_C: begin
        ctl_o.rd_en = 1'b1;
        rd_addr_o   = x;
      end
      ST_CELL_E: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.acc   = ACC_INIT;
        rd_addr_o   = x + AW'(1);
      end
      ST_CELL_W: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.acc   = ACC_ADD;
        rd_addr_o   = x - AW'(1);
      end
      ST_CELL_N: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.acc   = ACC_ADD;
        rd_addr_o   = x - AW'(P);
      end
      ST_CELL_S: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.acc   = ACC_ADD;
        rd_addr_o   = x + AW'(P);
      end
      ST_CELL_MUL: ctl_o.acc = ACC_MUL;
      ST_CELL_F:   ctl_o.acc = ACC_FOLD;
      ST_CELL_WR: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_nxt = 1'b1;
        ctl_o.wr_src = WS_CALC;
        wr_addr_o    = x;
        if (last_col && last_row) begin
          ctl_o.swap    = 1'b1;
          ctl_o.emit    = EM_OK;
          ctl_o.emit_ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ hdl/wave_equation_2d_q15_step.sv @@
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+---------------------------
// command   | in        | start_i & !busy_o     | cmd_i   (wes_pkg::in_t)
// result    | out       | done_o, one cycle     | res_o   (wes_pkg::out_t)
// config    | in/out    | APB, psel/penable     | paddr, pwdata, prdata
//
// After reset a clearing pass zeroes all (MAX_WIDTH+2)*(MAX_HEIGHT+2) cells of
// both grids (4356 at defaults), with busy_o high. A write answers in the cycle
// after the transaction; a read via the memory read and result registers.
// A step copies the border cells, each by a read then a write, then takes each
// inner cell through C, E, W, N, S, MUL, F and WR, as each grid memory has
// one read port. The result cannot be stalled; done_o is a one-cycle strobe.
module wave_equation_2d_q15_step #(
  parameter int unsigned MAX_WIDTH  = wes_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = wes_pkg::DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  wes_pkg::in_t  cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output wes_pkg::out_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import wes_pkg::*;

  localparam int unsigned AW = $clog2((MAX_WIDTH + 2) * (MAX_HEIGHT + 2));

  cfg_t cfg_q;
  reg_e reg_sel;
  ctl_t ctl;
  logic [AW-1:0] rd_addr, wr_addr;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[4:2]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.courant_sq    <= RST_COURANT;
      cfg_q.damping_shift <= RST_DAMP;
      cfg_q.half_duplex   <= 1'b0;
      cfg_q.x_cylindrical <= 1'b0;
      cfg_q.grid_width    <= RST_WIDTH;
      cfg_q.grid_height   <= RST_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_COURANT: cfg_q.courant_sq    <= pwdata[15:0];
        REG_DAMP:    cfg_q.damping_shift <= pwdata[3:0];
        REG_HALF:    cfg_q.half_duplex   <= pwdata[0];
        REG_CYL:     cfg_q.x_cylindrical <= pwdata[0];
        REG_WIDTH:   cfg_q.grid_width    <= pwdata[6:0];
        REG_HEIGHT:  cfg_q.grid_height   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      REG_COURANT: prdata = {16'b0, cfg_q.courant_sq};
      REG_DAMP:    prdata = {28'b0, cfg_q.damping_shift};
      REG_HALF:    prdata = {31'b0, cfg_q.half_duplex};
      REG_CYL:     prdata = {31'b0, cfg_q.x_cylindrical};
      REG_WIDTH:   prdata = {25'b0, cfg_q.grid_width};
      REG_HEIGHT:  prdata = {25'b0, cfg_q.grid_height};
      default:     prdata = '0;
    endcase
  end

  wes_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .ctl_o    (ctl),
    .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr)
  );

  wes_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ctl_i       (ctl),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .cell_value_i(cmd_i.cell_value),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

@@ hdl/wes_checker.sv @@
`include "assert_macros.svh"

module wes_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input wes_pkg::in_t  cmd_i,
  input logic          busy_o,
  input logic          done_o,
  input wes_pkg::out_t res_o
);
  import wes_pkg::*;

  logic acc_wr, acc_rd, acc_step;

  assign acc_wr   = start_i && !busy_o && (cmd_i.func == FN_WRITE);
  assign acc_rd   = start_i && !busy_o &&
                    ((cmd_i.func == FN_RD_CUR) || (cmd_i.func == FN_RD_PRV));
  assign acc_step = start_i && !busy_o && (cmd_i.func == FN_STEP);

  // A write answers in the next cycle with a zero value
  `WES_ASSERT_NEXT(a_write_done, clk_i, rst_ni, acc_wr, done_o && (res_o.read_value == '0), "write result missing")

  // A read keeps the block busy with no answer in the following cycle, then answers from the result register
  `WES_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, acc_rd, busy_o && !done_o, "read timing wrong")
  `WES_ASSERT(a_read_done, clk_i, rst_ni, acc_rd |-> ##2 done_o, "read result missing")

  // A step keeps the block busy
  `WES_ASSERT_NEXT(a_step_busy, clk_i, rst_ni, acc_step, busy_o, "step not started")

  // Out-of-range results carry zero
  `WES_ASSERT(a_oor_zero, clk_i, rst_ni, (done_o && !res_o.in_range) |-> (res_o.read_value == '0), "nonzero out-of-range value")

endmodule

bind wave_equation_2d_q15_step wes_checker u_wes_checker (.*);
